[design/qrm_pkg.sv]
// shared constants and types for the quaternion to rotation matrix core
`default_nettype none
package qrm_pkg;
    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 14;
    localparam int LANES              = 9;

    // pipeline status that travels with every item
    typedef struct packed {
        logic vld;
        logic zero;
    } qrm_ctl_t;
endpackage
`default_nettype wire

[design/quaternion_to_rotation_matrix_core.sv]
// top level: quaternion in, normalised 3x3 rotation matrix out
// Takes one quaternion per cycle whenever start is high; busy is always low.
// Each item, once taken, passes in order through these pipeline stages:
// one multiply stage, one sum stage, FRACTION_BITS+1 divider stages giving
// one quotient bit each, and a rounding stage. done marks the result cycle
// and there is no back-pressure, so the result must be taken then.
// An all-zero quaternion gives the identity matrix with zero_norm set.
`default_nettype none
module quaternion_to_rotation_matrix_core #(
    parameter int COMPONENT_BITS = qrm_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = qrm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_w,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_x,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_y,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_z,
    output logic                                  done,
    output logic signed [FRACTION_BITS+1:0]       r00,
    output logic signed [FRACTION_BITS+1:0]       r01,
    output logic signed [FRACTION_BITS+1:0]       r02,
    output logic signed [FRACTION_BITS+1:0]       r10,
    output logic signed [FRACTION_BITS+1:0]       r11,
    output logic signed [FRACTION_BITS+1:0]       r12,
    output logic signed [FRACTION_BITS+1:0]       r20,
    output logic signed [FRACTION_BITS+1:0]       r21,
    output logic signed [FRACTION_BITS+1:0]       r22,
    output logic                                  zero_norm
);
    import qrm_pkg::*;

    localparam int NW      = 2 * COMPONENT_BITS + 1;
    localparam int LATENCY = FRACTION_BITS + 4;

    qrm_ctl_t                       sum_ctl, out_ctl;
    logic [NW-1:0]                  den;
    logic [NW-1:0]                  mag [0:LANES-1];
    logic                           neg [0:LANES-1];
    logic signed [FRACTION_BITS+1:0] res [0:LANES-1];

    assign busy = 1'b0;

    qrm_products #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_products (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (start & ~busy),
        .comp_w (comp_w),
        .comp_x (comp_x),
        .comp_y (comp_y),
        .comp_z (comp_z),
        .ctl    (sum_ctl),
        .den    (den),
        .mag    (mag),
        .neg    (neg)
    );

    qrm_divider #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sum_ctl),
        .den     (den),
        .mag     (mag),
        .neg     (neg),
        .out_ctl (out_ctl),
        .res     (res)
    );

    assign done      = out_ctl.vld;
    assign zero_norm = out_ctl.zero;
    assign r00 = res[0];
    assign r01 = res[1];
    assign r02 = res[2];
    assign r10 = res[3];
    assign r11 = res[4];
    assign r12 = res[5];
    assign r20 = res[6];
    assign r21 = res[7];
    assign r22 = res[8];

    localparam logic signed [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1) << FRACTION_BITS;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without an item taken");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_norm) |-> (r00 == ONE && r11 == ONE && r22 == ONE && r01 == 0))
        else $error("zero quaternion did not give identity");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (r00 <= ONE && r00 >= -ONE && r11 <= ONE && r11 >= -ONE
                  && r22 <= ONE && r22 >= -ONE))
        else $error("diagonal entry out of range");
endmodule
`default_nettype wire

[design/qrm_products.sv]
// products, norm and numerators of the nine matrix entries (two stages)
`default_nettype none
module qrm_products #(
    parameter int COMPONENT_BITS = qrm_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_vld,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_w,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_x,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_y,
    input  wire logic signed [COMPONENT_BITS-1:0] comp_z,
    output qrm_pkg::qrm_ctl_t                     ctl,
    output logic [2*COMPONENT_BITS:0]             den,
    output logic [2*COMPONENT_BITS:0]             mag [0:qrm_pkg::LANES-1],
    output logic                                  neg [0:qrm_pkg::LANES-1]
);
    import qrm_pkg::*;

    localparam int PW = 2 * COMPONENT_BITS;
    localparam int NW = PW + 1;
    localparam int NS = PW + 2;

    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic                 vld1_reg;

    logic signed [NS-1:0] num_next [0:LANES-1];
    logic signed [NS-1:0] n2_next;
    logic [NW-1:0]        mag_reg [0:LANES-1];
    logic                 neg_reg [0:LANES-1];
    logic [NW-1:0]        den_reg;
    qrm_ctl_t             ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            ctl_reg  <= '0;
        end
        else
        begin
            vld1_reg     <= in_vld;
            ctl_reg.vld  <= vld1_reg;
            ctl_reg.zero <= (n2_next == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        ww_reg <= comp_w * comp_w;
        xx_reg <= comp_x * comp_x;
        yy_reg <= comp_y * comp_y;
        zz_reg <= comp_z * comp_z;
        xy_reg <= comp_x * comp_y;
        xz_reg <= comp_x * comp_z;
        yz_reg <= comp_y * comp_z;
        wx_reg <= comp_w * comp_x;
        wy_reg <= comp_w * comp_y;
        wz_reg <= comp_w * comp_z;
    end

    always_comb
    begin
        n2_next     = NS'(ww_reg) + NS'(xx_reg) + NS'(yy_reg) + NS'(zz_reg);
        num_next[0] = NS'(ww_reg) + NS'(xx_reg) - NS'(yy_reg) - NS'(zz_reg);
        num_next[1] = (NS'(xy_reg) - NS'(wz_reg)) <<< 1;
        num_next[2] = (NS'(xz_reg) + NS'(wy_reg)) <<< 1;
        num_next[3] = (NS'(xy_reg) + NS'(wz_reg)) <<< 1;
        num_next[4] = NS'(ww_reg) - NS'(xx_reg) + NS'(yy_reg) - NS'(zz_reg);
        num_next[5] = (NS'(yz_reg) - NS'(wx_reg)) <<< 1;
        num_next[6] = (NS'(xz_reg) - NS'(wy_reg)) <<< 1;
        num_next[7] = (NS'(yz_reg) + NS'(wx_reg)) <<< 1;
        num_next[8] = NS'(ww_reg) - NS'(xx_reg) - NS'(yy_reg) + NS'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        den_reg <= NW'(n2_next);
        for (int i = 0; i < LANES; i++)
        begin
            neg_reg[i] <= num_next[i][NS-1];
            mag_reg[i] <= num_next[i][NS-1] ? NW'(-num_next[i]) : NW'(num_next[i]);
        end
    end

    assign ctl = ctl_reg;
    assign den = den_reg;
    assign mag = mag_reg;
    assign neg = neg_reg;
endmodule
`default_nettype wire

[design/qrm_divider.sv]
// nine-lane pipelined restoring divider, one quotient bit per stage, with rounding
`default_nettype none
module qrm_divider #(
    parameter int COMPONENT_BITS = qrm_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = qrm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  qrm_pkg::qrm_ctl_t                ctl,
    input  wire logic [2*COMPONENT_BITS:0]   den,
    input  wire logic [2*COMPONENT_BITS:0]   mag [0:qrm_pkg::LANES-1],
    input  wire logic                        neg [0:qrm_pkg::LANES-1],
    output qrm_pkg::qrm_ctl_t                out_ctl,
    output logic signed [FRACTION_BITS+1:0]  res [0:qrm_pkg::LANES-1]
);
    import qrm_pkg::*;

    localparam int NW = 2 * COMPONENT_BITS + 1;
    localparam int QW = FRACTION_BITS + 2;
    localparam int F  = FRACTION_BITS;

    logic [NW-1:0] rem_reg [0:F][0:LANES-1];
    logic [QW-1:0] q_reg   [0:F][0:LANES-1];
    logic          neg_reg [0:F][0:LANES-1];
    logic [NW-1:0] den_reg [0:F];
    qrm_ctl_t      ctl_reg [0:F];

    logic signed [QW-1:0] res_reg [0:LANES-1];
    qrm_ctl_t             out_ctl_reg;

    // first stage takes the integer bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int i = 0; i < LANES; i++)
        begin
            neg_reg[0][i] <= neg[i];
            if (mag[i] >= den)
            begin
                rem_reg[0][i] <= mag[i] - den;
                q_reg[0][i]   <= QW'(1);
            end
            else
            begin
                rem_reg[0][i] <= mag[i];
                q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= F; k++)
    begin : g_step
        logic [NW:0] trial [0:LANES-1];

        always_comb
        begin
            for (int i = 0; i < LANES; i++)
            begin
                trial[i] = {rem_reg[k-1][i], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_reg[k-1];
            for (int i = 0; i < LANES; i++)
            begin
                neg_reg[k][i] <= neg_reg[k-1][i];
                if (trial[i] >= {1'b0, den_reg[k-1]})
                begin
                    rem_reg[k][i] <= NW'(trial[i] - {1'b0, den_reg[k-1]});
                    q_reg[k][i]   <= {q_reg[k-1][i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k][i] <= NW'(trial[i]);
                    q_reg[k][i]   <= {q_reg[k-1][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero, clamp, restore sign; zero norm gives identity
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic [QW-1:0] qr_next [0:LANES-1];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            qr_next[i] = q_reg[F][i] +
                QW'({rem_reg[F][i], 1'b0} >= {1'b0, den_reg[F]});
            if (qr_next[i] > ONE)
            begin
                qr_next[i] = ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ctl_reg <= '0;
        end
        else
        begin
            out_ctl_reg <= ctl_reg[F];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (ctl_reg[F].zero)
            begin
                res_reg[i] <= (i % 4 == 0) ? ONE : '0;
            end
            else
            begin
                res_reg[i] <= neg_reg[F][i] ? -qr_next[i] : qr_next[i];
            end
        end
    end

    assign out_ctl = out_ctl_reg;
    assign res     = res_reg;
endmodule
`default_nettype wire

[dv/quaternion_to_rotation_matrix_core_tb.sv]
// testbench for the quaternion to rotation matrix core: directed table then random items
`default_nettype none
module quaternion_to_rotation_matrix_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = qrm_pkg::COMPONENT_BITS_DEF;
    localparam int FB = qrm_pkg::FRACTION_BITS_DEF;
    localparam int OB = FB + 2;
    localparam int LATENCY = FB + 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1030;
    localparam logic signed [OB-1:0] ONE = OB'(1 << FB);

    typedef struct {
        logic signed [OB-1:0] r [9];
        logic                 zero;
    } matrix_t;

    typedef struct {
        logic signed [CB-1:0] q [4];
        logic                 has_exp;
        matrix_t              m;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [CB-1:0] comp_w = '0, comp_x = '0, comp_y = '0, comp_z = '0;
    wire logic busy, done, zero_norm;
    wire logic signed [OB-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

    quaternion_to_rotation_matrix_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .comp_w(comp_w), .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
        .done(done), .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
        .r12(r12), .r20(r20), .r21(r21), .r22(r22), .zero_norm(zero_norm)
    );

    always #5 clk = ~clk;

    matrix_t pending_matrices [$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      sender_idle_pct = 0;

    // round(num * 2^F / n2), ties away from zero
    function automatic logic signed [OB-1:0] ratio_q(longint num, longint n2);
        longint mag;
        longint q;
        longint rem;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FB) / n2;
        rem = (mag <<< FB) % n2;
        if (2 * rem >= n2) q = q + 1;
        if (q > (longint'(1) <<< FB)) q = longint'(1) <<< FB;
        return OB'((num < 0) ? -q : q);
    endfunction

    function automatic matrix_t rotation_of(logic signed [CB-1:0] q [4]);
        matrix_t m;
        longint w, x, y, z, n2;
        longint num [9];
        w = q[0]; x = q[1]; y = q[2]; z = q[3];
        n2 = w*w + x*x + y*y + z*z;
        if (n2 == 0) begin
            foreach (m.r[k]) m.r[k] = (k % 4 == 0) ? ONE : '0;
            m.zero = 1'b1;
            return m;
        end
        num[0] = w*w + x*x - y*y - z*z;
        num[1] = 2 * (x*y - w*z);
        num[2] = 2 * (x*z + w*y);
        num[3] = 2 * (x*y + w*z);
        num[4] = w*w - x*x + y*y - z*z;
        num[5] = 2 * (y*z - w*x);
        num[6] = 2 * (x*z - w*y);
        num[7] = 2 * (y*z + w*x);
        num[8] = w*w - x*x - y*y + z*z;
        foreach (m.r[k]) m.r[k] = ratio_q(num[k], n2);
        m.zero = 1'b0;
        return m;
    endfunction

    function automatic row_t mk(int w, int x, int y, int z, bit ident = 0, bit rot = 0);
        row_t t;
        t.q[0] = CB'(w); t.q[1] = CB'(x); t.q[2] = CB'(y); t.q[3] = CB'(z);
        t.has_exp = ident | rot;
        t.m.zero = 1'b0;
        foreach (t.m.r[k]) t.m.r[k] = (ident && k % 4 == 0) ? ONE : '0;
        if (ident && w == 0 && x == 0 && y == 0 && z == 0) t.m.zero = 1'b1;
        if (rot) begin
            // rotation by pi about x: diag(1,-1,-1)
            t.m.r[0] = ONE; t.m.r[4] = -ONE; t.m.r[8] = -ONE;
        end
        return t;
    endfunction

    // result checking
    always @(posedge clk) begin
        matrix_t e;
        logic signed [OB-1:0] got [9];
        if (rst_n && done) begin
            got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
            if (pending_matrices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no item outstanding");
            end else begin
                e = pending_matrices.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== e.r[k]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("r%0d%0d exp %0d got %0d", k / 3, k % 3, e.r[k], got[k]);
                    end
                if (zero_norm !== e.zero) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("zero_norm exp %0b got %0b", e.zero, zero_norm);
                end
            end
        end
    end

    // watchdog on cycles with no item taken or result seen
    always @(posedge clk) begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_rotation_matrix_core: mismatch");
            $finish;
        end
    end

    // start stays high after an item so back to back items need one write per edge
    task automatic send(row_t t);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        comp_w <= t.q[0]; comp_x <= t.q[1]; comp_y <= t.q[2]; comp_z <= t.q[3];
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_matrices.push_back(t.has_exp ? t.m : rotation_of(t.q));
    endtask

    function automatic int rnd_comp(int mode);
        case (mode)
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(15) - 8;
            2: return ($urandom_range(1)) ? 32767 - $urandom_range(3)
                                          : -32768 + $urandom_range(3);
            default: return $urandom_range(511) - 256;
        endcase
    endfunction

    initial begin
        row_t directed [$];
        row_t t;
        int phase_pct [4];
        phase_pct = '{0, 88, 0, 26};
        directed.push_back(mk(0, 0, 0, 0, 1));
        directed.push_back(mk(1, 0, 0, 0, 1));
        directed.push_back(mk(32767, 0, 0, 0, 1));
        directed.push_back(mk(-32768, 0, 0, 0, 1));
        directed.push_back(mk(-1, 0, 0, 0, 1));
        directed.push_back(mk(0, 32767, 0, 0, 0, 1));
        directed.push_back(mk(0, -32768, 0, 0, 0, 1));
        directed.push_back(mk(0, 0, 32767, 0));
        directed.push_back(mk(0, 0, 0, -32768));
        directed.push_back(mk(-32768, -32768, -32768, -32768));
        directed.push_back(mk(32767, 32767, 32767, 32767));
        directed.push_back(mk(32767, -32768, 32767, -32768));
        directed.push_back(mk(1, 1, 0, 0));
        directed.push_back(mk(3, 1, 0, 0));
        directed.push_back(mk(1, 2, 3, 4));
        directed.push_back(mk(-5, 7, -11, 13));
        directed.push_back(mk(0, 0, 0, 1));
        directed.push_back(mk(21845, -21846, 10922, -1));
        directed.push_back(mk(16'h5555, 16'h2AAA, -16'h5555, 16'h0F0F));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send(directed[i]);

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = phase_pct[p];
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                int mode;
                mode = $urandom_range(3);
                t = mk(rnd_comp(mode), rnd_comp(mode), rnd_comp(mode), rnd_comp(mode));
                if ($urandom_range(49) == 0) t = mk(0, 0, 0, 0);
                send(t);
            end
            // drain before the next phase
            start <= 1'b0;
            while (pending_matrices.size() != 0) @(posedge clk);
        end

        repeat (LATENCY + 4) @(posedge clk);
        if (mismatches == 0 && pending_matrices.size() == 0)
            $display("quaternion_to_rotation_matrix_core: match");
        else
            $display("quaternion_to_rotation_matrix_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
